### rtl/dcmqe_pkg.sv
// Shared types, constants and helper functions for the DC motor encoder model.
// No dependencies; used by the controller, the datapath and the top level.
package dcmqe_pkg;

  localparam int unsigned TF_W      = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned SPEED_W   = 7;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned PWM_W     = 8;
  localparam int unsigned MAG_W     = 7;
  localparam int unsigned DVS_W     = MAG_W + 2;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned DIV_STEPS = TF_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [TF_W-1:0]  TICK_FREQ_RESET    = 32'd1000000;
  localparam logic [PWM_W-1:0] PWM_FLOOR          = 8'd55;
  localparam logic [POS_W:0]   POSITIONS_PER_TURN = 9'd200;
  localparam logic [MAG_W-1:0] MAG_STEP_MIN       = 7'd3;
  localparam logic [DCNT_W-1:0] DIV_LAST          = DCNT_W'(DIV_STEPS - 1);

  // Stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_DELTA,
    ST_DIV
  } dcmqe_state_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic pos_upd;
    logic delta;
    logic div_step;
    logic div_finish;
    logic load_out;
  } dcmqe_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic need_div;
  } dcmqe_sts_t;

  // floor(x/3) for x < 128 by reciprocal multiply
  function automatic logic [STEP_W-1:0] div3(input logic [SPEED_W-1:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return prod[14:9];
  endfunction

  // Encoder phase that a position sits in: (x mod 10) * 2 / 5
  function automatic logic [PHASE_W-1:0] phase_of_pos(input logic [POS_W-1:0] x);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    logic [PHASE_W-1:0] ph;
    prod = 16'(x) * 16'd205;
    q    = prod[15:11];
    r    = x - ({3'b0, q} * 8'd10);
    case (r[3:0])
      4'd0, 4'd1, 4'd2: ph = 2'd0;
      4'd3, 4'd4:       ph = 2'd1;
      4'd5, 4'd6, 4'd7: ph = 2'd2;
      default:          ph = 2'd3;
    endcase
    return ph;
  endfunction

  // Drive the pin that belongs to a phase; pins = {pin_b, pin_a}
  function automatic logic [1:0] drive_pins(input logic [PHASE_W-1:0] ph,
                                            input logic [1:0] pins);
    logic [1:0] p;
    p = pins;
    case (ph)
      2'd0:    p[0] = 1'b0;
      2'd1:    p[1] = 1'b1;
      2'd2:    p[0] = 1'b1;
      default: p[1] = 1'b0;
    endcase
    return p;
  endfunction

endpackage

### rtl/dcmqe_ctrl.sv
// Controller state machine: sequences frame requests through position update,
// delta evaluation and the serial interval divider. Depends on dcmqe_pkg.
module dcmqe_ctrl
  import dcmqe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       is_tick,
  input  logic       m_tready,
  input  dcmqe_sts_t sts,
  output logic       s_tready,
  output dcmqe_cmd_t cmd
);

  dcmqe_state_t      state, state_next;
  logic [DCNT_W-1:0] div_cnt, div_cnt_next;
  logic              accept;

  assign s_tready = (state == ST_IDLE) && (!sts.out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && !is_tick) state_next = ST_POS;
      ST_POS:   state_next = ST_DELTA;
      ST_DELTA: state_next = sts.need_div ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_cnt == DIV_LAST) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    div_cnt_next = div_cnt;
    case (state)
      ST_IDLE: begin
        cmd.capture  = accept && !is_tick;
        cmd.tick     = accept && is_tick;
        cmd.load_out = accept && is_tick;
      end
      ST_POS: cmd.pos_upd = 1'b1;
      ST_DELTA: begin
        cmd.delta    = 1'b1;
        cmd.load_out = 1'b1;
        div_cnt_next = '0;
      end
      ST_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.div_finish = (div_cnt == DIV_LAST);
        div_cnt_next   = div_cnt + 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/dcmqe_dp.sv
// Datapath: motor state, encoder phase and pins, tick counter, restoring
// divider for the step interval and the output register. Depends on dcmqe_pkg.
module dcmqe_dp
  import dcmqe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dcmqe_cmd_t           cmd,
  output dcmqe_sts_t           sts,
  input  logic                 cfg_we,
  input  logic [TF_W-1:0]      cfg_data,
  input  logic                 in_a,
  input  logic                 in_b,
  input  logic [PWM_W-1:0]     in_level,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic                 enc_a,
  output logic                 enc_b,
  output logic [POS_W-1:0]     position,
  output logic [SPEED_W-1:0]   motor_speed,
  output logic                 direction
);

  logic [TF_W-1:0]    tick_freq;
  logic [POS_W-1:0]   pos, pos_next, prev_pos, prev_pos_next;
  logic [SPEED_W-1:0] cur_speed, cur_speed_next;
  logic               dir_reg, dir_reg_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [TF_W-1:0]    tick_count, tick_count_next;
  logic [TF_W-1:0]    interval, interval_next;
  logic [1:0]         pins, pins_next;

  logic               fr_a, fr_b;
  logic [PWM_W-1:0]   fr_level;

  logic [TF_W-1:0]    div_quo, div_quo_next;
  logic [DVS_W-1:0]   div_rem, div_rem_next, div_dvs;

  // frame arithmetic
  logic [PWM_W-1:0]   level;
  logic [PWM_W-1:0]   lvl_diff;
  logic [SPEED_W-1:0] speed_raw;
  logic [STEP_W-1:0]  step;
  logic [POS_W:0]     fwd_sum, rev_sum;
  logic signed [POS_W+1:0] delta;
  logic [MAG_W-1:0]   mag;

  // tick arithmetic
  logic [TF_W:0]      tick_inc;
  logic [PHASE_W-1:0] tick_phase;

  // divider step
  logic [DVS_W:0]     rem_sh;
  logic               rem_ge;

  assign level     = (fr_level < PWM_FLOOR) ? PWM_FLOOR : fr_level;
  assign lvl_diff  = level - PWM_FLOOR;
  assign speed_raw = lvl_diff[SPEED_W:1];
  assign step      = div3(speed_raw);
  assign fwd_sum   = {1'b0, pos} + {3'b0, step};
  assign rev_sum   = ({1'b0, pos} >= {3'b0, step}) ? ({1'b0, pos} - {3'b0, step})
                   : ({1'b0, pos} + POSITIONS_PER_TURN - {3'b0, step});

  // wrapped delta between new and previous position, magnitude at most 100
  always_comb begin
    delta = $signed({2'b0, pos}) - $signed({2'b0, prev_pos});
    if (delta < -$signed({1'b0, POSITIONS_PER_TURN >> 1}))
      delta = delta + $signed({1'b0, POSITIONS_PER_TURN});
    else if (delta > $signed({1'b0, POSITIONS_PER_TURN >> 1}))
      delta = delta - $signed({1'b0, POSITIONS_PER_TURN});
    mag = delta[POS_W+1] ? MAG_W'(-delta) : MAG_W'(delta);
  end

  assign sts.need_div  = (mag >= MAG_STEP_MIN);
  assign sts.out_valid = m_tvalid;

  assign tick_inc   = {1'b0, tick_count} + 1'b1;
  assign tick_phase = dir_reg ? phase + 1'b1 : phase - 1'b1;

  assign rem_sh = {div_rem, div_quo[TF_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_dvs};

  always_comb begin
    pos_next        = pos;
    prev_pos_next   = prev_pos;
    cur_speed_next  = cur_speed;
    dir_reg_next    = dir_reg;
    phase_next      = phase;
    tick_count_next = tick_count;
    interval_next   = interval;
    pins_next       = pins;
    div_quo_next    = {div_quo[TF_W-2:0], rem_ge};
    div_rem_next    = rem_ge ? DVS_W'(rem_sh - {1'b0, div_dvs}) : rem_sh[DVS_W-1:0];

    if (cmd.tick && (interval != '0)) begin
      if (tick_inc >= {1'b0, interval}) begin
        tick_count_next = '0;
        phase_next      = tick_phase;
        pins_next       = drive_pins(tick_phase, pins);
      end else begin
        tick_count_next = tick_inc[TF_W-1:0];
      end
    end

    if (cmd.pos_upd) begin
      cur_speed_next = speed_raw;
      if (fr_a && !fr_b) begin
        dir_reg_next = 1'b0;
        pos_next     = (fwd_sum >= POSITIONS_PER_TURN) ? POS_W'(fwd_sum - POSITIONS_PER_TURN)
                                                     : fwd_sum[POS_W-1:0];
      end else if (!fr_a && fr_b) begin
        dir_reg_next = 1'b1;
        pos_next     = rev_sum[POS_W-1:0];
      end else begin
        cur_speed_next = '0;
      end
    end

    if (cmd.delta) begin
      prev_pos_next = pos;
      interval_next = '0;
      if (mag != '0 && !sts.need_div) begin
        phase_next = phase_of_pos(prev_pos);
        pins_next  = drive_pins(phase_of_pos(prev_pos), pins);
      end
    end

    if (cmd.div_finish)
      interval_next = div_quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_freq  <= TICK_FREQ_RESET;
      pos        <= '0;
      prev_pos   <= '0;
      cur_speed  <= '0;
      dir_reg    <= 1'b0;
      phase      <= '0;
      tick_count <= '0;
      interval   <= '0;
      pins       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we)
        tick_freq <= cfg_data;
      pos        <= pos_next;
      prev_pos   <= prev_pos_next;
      cur_speed  <= cur_speed_next;
      dir_reg    <= dir_reg_next;
      phase      <= phase_next;
      tick_count <= tick_count_next;
      interval   <= interval_next;
      pins       <= pins_next;
      if (cmd.load_out)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fr_a     <= in_a;
      fr_b     <= in_b;
      fr_level <= in_level;
    end
    if (cmd.delta) begin
      div_quo <= tick_freq;
      div_rem <= '0;
      div_dvs <= {mag, 2'b00};
    end else if (cmd.div_step) begin
      div_quo <= div_quo_next;
      div_rem <= div_rem_next;
    end
    if (cmd.load_out) begin
      enc_a       <= pins_next[0];
      enc_b       <= pins_next[1];
      position    <= pos_next;
      motor_speed <= cur_speed_next;
      direction   <= dir_reg_next;
    end
  end

endmodule

### rtl/dc_motor_quadrature_encoder_model_core.sv
// Top level of the DC motor / quadrature encoder model: ports, stream packing,
// and the controller and datapath. Depends on dcmqe_pkg, dcmqe_ctrl, dcmqe_dp.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   s_       | in        | s_tvalid/s_tready  | tuser: action; tdata: bridge, PWM
//   m_       | out       | m_tvalid/m_tready  | tdata: encoder pins, pos, speed, dir
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_data: tick_freq
//
// A tick request's result is loaded into the output register on the same edge
// that takes the request, so ticks stream at one per clock while the output
// side keeps pace.
// A frame request runs through capture, position update and delta; when the
// wrapped delta is three or more the 32-step restoring divider for the step
// interval runs after them, and the frame holds the input until it is done.
// Reset (rst, synchronous) clears all motor state and restores tick_freq.
// The output register separates the sides: a new request is taken while a
// result waits, as long as that result is taken in the same cycle.
module dc_motor_quadrature_encoder_model_core
  import dcmqe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [0] bridge_a, [1] bridge_b, [9:2] pwm_level
  input  logic [0:0]           s_tuser,  // [0] action (0 frame, 1 tick)
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // [0] enc_a, [1] enc_b, [9:2] position,
                                         // [16:10] motor_speed, [17] direction
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TF_W-1:0]      cfg_data
);

  dcmqe_cmd_t         cmd;
  dcmqe_sts_t         sts;
  logic               enc_a, enc_b, direction;
  logic [POS_W-1:0]   position;
  logic [SPEED_W-1:0] motor_speed;

  // Configuration is to be written only while idle (the block does not enforce this): always take it
  assign cfg_ready = 1'b1;

  dcmqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .is_tick  (s_tuser[0]),
    .m_tready (m_tready),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  dcmqe_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .in_a        (s_tdata[0]),
    .in_b        (s_tdata[1]),
    .in_level    (s_tdata[9:2]),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .enc_a       (enc_a),
    .enc_b       (enc_b),
    .position    (position),
    .motor_speed (motor_speed),
    .direction   (direction)
  );

  // Pack the result fields from bit 0 upward, pad to whole bytes
  assign m_tdata = {6'b0, direction, motor_speed, position, enc_b, enc_a};

endmodule

### rtl/dcmqe_checker.sv
// Port-level checker for the DC motor encoder model, bound to the top level.
// Depends on dcmqe_pkg and dc_motor_quadrature_encoder_model_core.
module dcmqe_checker
  import dcmqe_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [0:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A tick request always produces a result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> m_tvalid)
    else $error("tick request gave no result");

  // Position stays within one turn, speed within range
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:2] < 8'd200) && (m_tdata[16:10] <= 7'd100))
    else $error("position or speed out of range");

  // Nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind dc_motor_quadrature_encoder_model_core dcmqe_checker u_dcmqe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
